[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the radix literal parser.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(name, clk, rstn, expr) \
    name: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");

// Consequence that must hold in the same cycle as its antecedent.
`define ASSERT_IMPLIES(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

[design/rlpc_pkg.sv]
// ----------------------------------------------------------------------------
// rlpc_pkg
// Types, codes and helpers for the radix literal parser and combiner.
// ----------------------------------------------------------------------------
package rlpc_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int ACC_EXT_W   = VALUE_WIDTH + 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [VALUE_WIDTH-1:0] OPND_LIMIT =
        VALUE_WIDTH'({(VALUE_WIDTH-1){1'b1}});

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LC    = 8'h63;
    localparam logic [7:0] CH_LX    = 8'h78;

    localparam logic [4:0] BASE_BIN = 5'd2;
    localparam logic [4:0] BASE_DEC = 5'd10;
    localparam logic [4:0] BASE_HEX = 5'd16;
    localparam logic [4:0] BASE_OCT = 5'd8;

    localparam logic [1:0] POS_MAX = 2'd3;

    // Register word index on the configuration port
    localparam logic REG_LEFT_VALUE = 1'b0;

    typedef logic [VALUE_WIDTH-1:0] rlpc_acc_t;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2
    } rlpc_cmd_t;

    typedef enum logic [1:0] {
        FMT_BIN = 2'd0,
        FMT_DEC = 2'd1,
        FMT_HEX = 2'd2,
        FMT_OCT = 2'd3
    } rlpc_fmt_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_MATCH  = 2'd1,
        ST_NO_DIGITS = 2'd2,
        ST_OVERFLOW  = 2'd3
    } rlpc_status_t;

    typedef enum logic [1:0] {
        PFX_NONE = 2'd0,
        PFX_HEX  = 2'd1,
        PFX_OCT  = 2'd2
    } rlpc_pfx_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
        logic [1:0] cmd;
    } rlpc_in_t;

    typedef struct packed {
        logic signed [31:0] result;
        logic [1:0]         format;
        logic [1:0]         status;
    } rlpc_out_t;

    // Classified literal handed from the front to the back
    typedef struct packed {
        rlpc_acc_t    operand;
        rlpc_fmt_t    fmt;
        rlpc_status_t status;
        logic [1:0]   cmd;
    } rlpc_op_t;

    typedef struct packed {
        rlpc_acc_t acc;
        logic      ovf;
    } rlpc_acc_res_t;

    // One digit into an accumulator; freeze on overflow past the operand limit
    function automatic rlpc_acc_res_t acc_step(input rlpc_acc_t acc, input logic ovf,
                                               input logic [4:0] base,
                                               input logic [3:0] d);
        logic [ACC_EXT_W-1:0] prod;
        rlpc_acc_res_t        r;
        prod  = ACC_EXT_W'(acc) * ACC_EXT_W'(base) + ACC_EXT_W'(d);
        r.acc = acc;
        r.ovf = ovf;
        if (!ovf)
        begin
            if (prod > ACC_EXT_W'(OPND_LIMIT))
                r.ovf = 1'b1;
            else
                r.acc = prod[VALUE_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

[design/rlpc_front.sv]
// ----------------------------------------------------------------------------
// rlpc_front
// Accepts characters, runs the per-format accumulators and classifies the
// literal on its last character.
// ----------------------------------------------------------------------------
module rlpc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               char_valid,
    input  rlpc_pkg::rlpc_in_t char_data,
    output logic               char_stall,
    input  logic               q_full,
    output logic               q_push,
    output rlpc_pkg::rlpc_op_t q_op
);

    logic [1:0]          pos_reg, pos_next;
    logic                first_zero_reg, first_zero_next;
    rlpc_pkg::rlpc_pfx_t prefix_reg, prefix_next;
    logic                bin_ok_reg, bin_ok_next;
    logic                dec_ok_reg, dec_ok_next;
    logic                hex_ok_reg, hex_ok_next;
    logic                oct_ok_reg, oct_ok_next;
    rlpc_pkg::rlpc_acc_t acc_reg [4];
    rlpc_pkg::rlpc_acc_t acc_next [4];
    logic [3:0]          ovf_reg, ovf_next;

    logic                fire;
    logic [7:0]          c;
    logic                is_dec, is_bin, is_oct, is_uhex;
    logic [3:0]          digit;
    rlpc_pkg::rlpc_acc_res_t st_bin, st_dec, st_hex, st_oct;

    assign char_stall = q_full;
    assign fire       = char_valid && !char_stall;
    assign c          = char_data.char_code;

    assign is_dec  = (c >= rlpc_pkg::CH_ZERO) && (c <= rlpc_pkg::CH_NINE);
    assign is_bin  = (c == rlpc_pkg::CH_ZERO) || (c == rlpc_pkg::CH_ONE);
    assign is_oct  = (c >= rlpc_pkg::CH_ZERO) && (c <= rlpc_pkg::CH_SEVEN);
    assign is_uhex = (c >= rlpc_pkg::CH_UA) && (c <= rlpc_pkg::CH_UF);

    always_comb
    begin
        if (is_dec)
            digit = 4'(c - rlpc_pkg::CH_ZERO);
        else if (is_uhex)
            digit = 4'(c - rlpc_pkg::CH_UA + 8'd10);
        else
            digit = 4'd0;
    end

    assign st_bin = rlpc_pkg::acc_step(acc_reg[0], ovf_reg[0], rlpc_pkg::BASE_BIN, digit);
    assign st_dec = rlpc_pkg::acc_step(acc_reg[1], ovf_reg[1], rlpc_pkg::BASE_DEC, digit);
    assign st_hex = rlpc_pkg::acc_step(acc_reg[2], ovf_reg[2], rlpc_pkg::BASE_HEX, digit);
    assign st_oct = rlpc_pkg::acc_step(acc_reg[3], ovf_reg[3], rlpc_pkg::BASE_OCT, digit);

    // Parse state after this character
    always_comb
    begin
        pos_next        = (pos_reg == rlpc_pkg::POS_MAX) ? pos_reg : pos_reg + 2'd1;
        first_zero_next = first_zero_reg;
        prefix_next     = prefix_reg;
        bin_ok_next     = bin_ok_reg;
        dec_ok_next     = dec_ok_reg;
        hex_ok_next     = hex_ok_reg;
        oct_ok_next     = oct_ok_reg;
        for (int i = 0; i < 4; i++)
            acc_next[i] = acc_reg[i];
        ovf_next = ovf_reg;

        if (is_bin)
        begin
            acc_next[0] = st_bin.acc;
            ovf_next[0] = st_bin.ovf;
        end
        else
            bin_ok_next = 1'b0;

        if (is_dec)
        begin
            acc_next[1] = st_dec.acc;
            ovf_next[1] = st_dec.ovf;
        end
        else
            dec_ok_next = 1'b0;

        if (pos_reg == 2'd0)
            first_zero_next = (c == rlpc_pkg::CH_ZERO);

        if (pos_reg == 2'd1)
        begin
            if (!first_zero_reg)
                prefix_next = rlpc_pkg::PFX_NONE;
            else if (c == rlpc_pkg::CH_LX)
                prefix_next = rlpc_pkg::PFX_HEX;
            else if (c == rlpc_pkg::CH_LC)
                prefix_next = rlpc_pkg::PFX_OCT;
            else
                prefix_next = rlpc_pkg::PFX_NONE;
        end

        // Tail digits follow the two-character prefix
        if (pos_reg[1])
        begin
            if (is_dec || is_uhex)
            begin
                acc_next[2] = st_hex.acc;
                ovf_next[2] = st_hex.ovf;
            end
            else
                hex_ok_next = 1'b0;

            if (is_oct)
            begin
                acc_next[3] = st_oct.acc;
                ovf_next[3] = st_oct.ovf;
            end
            else
                oct_ok_next = 1'b0;
        end
    end

    // Classify on the last character, first matching format wins
    always_comb
    begin
        q_op.cmd    = char_data.cmd;
        q_op.fmt    = rlpc_pkg::FMT_BIN;
        q_op.status = rlpc_pkg::ST_OK;

        if (bin_ok_reg && (c == rlpc_pkg::CH_LB))
        begin
            q_op.fmt = rlpc_pkg::FMT_BIN;
            if (pos_reg == 2'd0)
                q_op.status = rlpc_pkg::ST_NO_DIGITS;
        end
        else if (dec_ok_next)
            q_op.fmt = rlpc_pkg::FMT_DEC;
        else if (first_zero_next && (prefix_next == rlpc_pkg::PFX_HEX) && hex_ok_next)
        begin
            q_op.fmt = rlpc_pkg::FMT_HEX;
            if (!pos_reg[1])
                q_op.status = rlpc_pkg::ST_NO_DIGITS;
        end
        else if (first_zero_next && (prefix_next == rlpc_pkg::PFX_OCT) && oct_ok_next)
        begin
            q_op.fmt = rlpc_pkg::FMT_OCT;
            if (!pos_reg[1])
                q_op.status = rlpc_pkg::ST_NO_DIGITS;
        end
        else
            q_op.status = rlpc_pkg::ST_NO_MATCH;

        if ((q_op.status == rlpc_pkg::ST_OK) && ovf_next[q_op.fmt])
            q_op.status = rlpc_pkg::ST_OVERFLOW;

        q_op.operand = acc_next[q_op.fmt];
    end

    assign q_push = fire && char_data.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= 2'd0;
            first_zero_reg <= 1'b0;
            prefix_reg     <= rlpc_pkg::PFX_NONE;
            bin_ok_reg     <= 1'b1;
            dec_ok_reg     <= 1'b1;
            hex_ok_reg     <= 1'b1;
            oct_ok_reg     <= 1'b1;
            ovf_reg        <= 4'd0;
            for (int i = 0; i < 4; i++)
                acc_reg[i] <= '0;
        end
        else if (fire)
        begin
            if (char_data.last)
            begin
                // Drop the literal's state, ready for the next one
                pos_reg        <= 2'd0;
                first_zero_reg <= 1'b0;
                prefix_reg     <= rlpc_pkg::PFX_NONE;
                bin_ok_reg     <= 1'b1;
                dec_ok_reg     <= 1'b1;
                hex_ok_reg     <= 1'b1;
                oct_ok_reg     <= 1'b1;
                ovf_reg        <= 4'd0;
                for (int i = 0; i < 4; i++)
                    acc_reg[i] <= '0;
            end
            else
            begin
                pos_reg        <= pos_next;
                first_zero_reg <= first_zero_next;
                prefix_reg     <= prefix_next;
                bin_ok_reg     <= bin_ok_next;
                dec_ok_reg     <= dec_ok_next;
                hex_ok_reg     <= hex_ok_next;
                oct_ok_reg     <= oct_ok_next;
                ovf_reg        <= ovf_next;
                for (int i = 0; i < 4; i++)
                    acc_reg[i] <= acc_next[i];
            end
        end
    end

endmodule

[design/rlpc_queue.sv]
// ----------------------------------------------------------------------------
// rlpc_queue
// Short queue of classified literals between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rlpc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rlpc_pkg::rlpc_op_t push_op,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output rlpc_pkg::rlpc_op_t head_op
);

    rlpc_pkg::rlpc_op_t              mem_reg [rlpc_pkg::QUEUE_DEPTH];
    logic [rlpc_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [rlpc_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [rlpc_pkg::QCNT_W-1:0]     count_reg, count_next;

    localparam logic [rlpc_pkg::QPTR_W-1:0] PTR_LAST = rlpc_pkg::QPTR_W'(rlpc_pkg::QUEUE_DEPTH - 1);
    localparam logic [rlpc_pkg::QCNT_W-1:0] CNT_FULL = rlpc_pkg::QCNT_W'(rlpc_pkg::QUEUE_DEPTH);

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_op    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_op;
    end

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_FULL)
    `ASSERT_IMPLIES(a_no_push_full, clk, rst_n, push, !full)
    `ASSERT_IMPLIES(a_no_pop_empty, clk, rst_n, pop, head_valid)

endmodule

[design/rlpc_back.sv]
// ----------------------------------------------------------------------------
// rlpc_back
// Combines the left value with the parsed operand and holds the result beat.
// ----------------------------------------------------------------------------
module rlpc_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [30:0]                    left_value,
    input  logic                           head_valid,
    input  rlpc_pkg::rlpc_op_t             head_op,
    output logic                           pop,
    output logic                           res_valid,
    output rlpc_pkg::rlpc_out_t            res_data,
    input  logic                           res_stall
);

    logic                            valid_reg, valid_next;
    rlpc_pkg::rlpc_out_t             data_reg;
    rlpc_pkg::rlpc_out_t             data_next;
    logic [rlpc_pkg::VALUE_WIDTH-1:0] lv;
    logic [rlpc_pkg::VALUE_WIDTH-1:0] comb_val;

    assign lv  = rlpc_pkg::VALUE_WIDTH'(left_value);
    // Take a new beat when the output register is empty or being drained
    assign pop = head_valid && (!valid_reg || !res_stall);

    always_comb
    begin
        case (head_op.cmd)
            rlpc_pkg::CMD_SUB: comb_val = lv - head_op.operand;
            rlpc_pkg::CMD_MUL: comb_val = lv * head_op.operand;
            default:           comb_val = lv + head_op.operand;
        endcase
    end

    always_comb
    begin
        data_next.format = head_op.fmt;
        data_next.status = head_op.status;
        if (head_op.status == rlpc_pkg::ST_OK)
            data_next.result = 32'(comb_val);
        else
            data_next.result = '0;
    end

    always_comb
    begin
        if (pop)
            valid_next = 1'b1;
        else if (!res_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            data_reg <= data_next;
    end

    assign res_valid = valid_reg;
    assign res_data  = data_reg;

endmodule

[design/radix_literal_parse_and_combine.sv]
// After its last character is accepted, a literal is written into the queue and
// then into the output register, which drives res_valid.
// Throughput: one character per cycle while the queue is not full; the two-entry literal queue absorbs output stalls.
// Each character updates constant-base multiply-add accumulators; the literal is classified on its last character.
// The combine stage has one multiplier, registered at the output.
// Reset clears the parse state, empties the queue, drops the output beat and sets left_value to zero.
// ----------------------------------------------------------------------------
// radix_literal_parse_and_combine
// Parses a binary, decimal, hex or octal literal and combines it with left_value.
// ----------------------------------------------------------------------------
module radix_literal_parse_and_combine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                char_valid,
    input  rlpc_pkg::rlpc_in_t  char_data,
    output logic                char_stall,
    output logic                res_valid,
    output rlpc_pkg::rlpc_out_t res_data,
    input  logic                res_stall,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [30:0]        left_reg;
    logic               cfg_wr;
    logic               q_push, q_full, q_pop, q_head_valid;
    rlpc_pkg::rlpc_op_t q_push_op, q_head_op;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == rlpc_pkg::REG_LEFT_VALUE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            left_reg <= '0;
        else if (cfg_wr)
            left_reg <= pwdata[30:0];
    end

    assign prdata = (paddr[2] == rlpc_pkg::REG_LEFT_VALUE) ? {1'b0, left_reg} : 32'd0;

    rlpc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_data  (char_data),
        .char_stall (char_stall),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_op       (q_push_op)
    );

    rlpc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_op    (q_push_op),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_op    (q_head_op)
    );

    rlpc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .left_value (left_reg),
        .head_valid (q_head_valid),
        .head_op    (q_head_op),
        .pop        (q_pop),
        .res_valid  (res_valid),
        .res_data   (res_data),
        .res_stall  (res_stall)
    );

endmodule
